@@ hw/rtl/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// COBS frame decoder package
// Shared widths, capacity and result codes for the COBS frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

   // Widths of the fields on the ports.
   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 9;

   // Largest length that fits in the length field.
   localparam int MAX_LENGTH = (1 << LENGTH_W) - 1;

   // Decoded bytes kept per frame before the frame counts as overflowed.
   localparam int FRAME_CAPACITY = 256;

   // The count must be able to hold the capacity itself.
   localparam int COUNT_W = $clog2(FRAME_CAPACITY + 1);

   // Width used when the count is compared against the largest length.
   localparam int LEN_CMP_W = (COUNT_W > LENGTH_W) ? COUNT_W : LENGTH_W;

   // Code byte of a full block, which carries no stripped zero.
   localparam logic [BYTE_W-1:0] FULL_BLOCK_CODE = 8'hff;

   // Frame delimiter byte.
   localparam logic [BYTE_W-1:0] DELIMITER = 8'h00;

   typedef enum logic [0:0] {
      KIND_PAYLOAD   = 1'b0,
      KIND_FRAME_END = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } frame_status_type;

endpackage : cfd_pkg

`default_nettype wire

@@ hw/rtl/cobs_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// COBS frame decoder
// Streams raw link bytes in and decoded payload bytes and frame-end requests out.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_ready, req_rx_byte) takes one raw byte
//   from the link per request. A zero byte closes the current frame. The
//   response channel (rsp_valid, rsp_ready, rsp_*) carries either a decoded
//   payload byte (rsp_item_kind = payload) or a frame-end marker with the
//   frame status and the number of decoded bytes kept.
//   A byte is captured in the input register, then decoded and written into
//   the response register. Bytes that produce no response (code bytes that
//   close no short block, bytes past capacity) simply leave the pipeline.
//   Throughput is one byte per cycle while the receiver takes responses; the
//   limit is the single decode step that updates the block and frame counters.
//   When the receiver stalls, the response register holds its request, the
//   input register holds the next byte, and req_ready falls once both are
//   full. Nothing is dropped or repeated across a stall.
//   Reset (synchronous, active high) empties both registers and clears the
//   block code, block position, decoded count and overflow flag, so the
//   first byte after reset starts a new frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cobs_frame_decoder_top
   import cfd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [BYTE_W-1:0]   req_rx_byte,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_item_kind,
   output logic [BYTE_W-1:0]        rsp_payload_byte,
   output logic [1:0]               rsp_frame_status,
   output logic [LENGTH_W-1:0]      rsp_frame_length
);

   // Input register.
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Decoder state.
   logic [BYTE_W-1:0]  block_code_ff,    block_code_in;
   logic [BYTE_W-1:0]  block_pos_ff,     block_pos_in;
   logic [COUNT_W-1:0] decoded_count_ff, decoded_count_in;
   logic               overflow_ff,      overflow_in;

   // Response register.
   logic                  rsp_valid_ff;
   item_kind_type         rsp_kind_ff,   rsp_kind_in;
   logic [BYTE_W-1:0]     rsp_byte_ff,   rsp_byte_in;
   frame_status_type      rsp_status_ff, rsp_status_in;
   logic [LENGTH_W-1:0]   rsp_length_ff, rsp_length_in;

   logic advance;
   logic is_delim;
   logic in_block;
   logic stripped;
   logic has_value;
   logic room;
   logic emit;
   logic [BYTE_W-1:0]    value;
   logic [LEN_CMP_W-1:0] count_ext;

   // The decode stage moves when the response register is free or being taken.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      is_delim  = (in_byte_ff == DELIMITER);
      in_block  = (block_pos_ff < block_code_ff);
      // A finished short block stands for a zero the encoder removed.
      stripped  = (block_code_ff != '0) && (block_code_ff != FULL_BLOCK_CODE);
      has_value = !is_delim && (in_block || stripped);
      value     = in_block ? in_byte_ff : '0;
      room      = (decoded_count_ff < COUNT_W'(FRAME_CAPACITY));
      emit      = is_delim || (has_value && room);

      count_ext = LEN_CMP_W'(decoded_count_ff);

      block_code_in    = block_code_ff;
      block_pos_in     = block_pos_ff;
      decoded_count_in = decoded_count_ff;
      overflow_in      = overflow_ff;

      rsp_kind_in   = KIND_PAYLOAD;
      rsp_byte_in   = value;
      rsp_status_in = STATUS_GOOD;
      rsp_length_in = '0;

      if (is_delim) begin
         rsp_kind_in = KIND_FRAME_END;
         rsp_byte_in = '0;
         priority if (overflow_ff) begin
            rsp_status_in = STATUS_OVERFLOW;
         end else if (decoded_count_ff == '0) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            rsp_status_in = STATUS_GOOD;
         end
         if (count_ext > LEN_CMP_W'(MAX_LENGTH)) begin
            rsp_length_in = LENGTH_W'(MAX_LENGTH);
         end else begin
            rsp_length_in = LENGTH_W'(count_ext);
         end
         block_code_in    = '0;
         block_pos_in     = '0;
         decoded_count_in = '0;
         overflow_in      = 1'b0;
      end else begin
         if (in_block) begin
            block_pos_in = block_pos_ff + 1'b1;
         end else begin
            block_code_in = in_byte_ff;
            block_pos_in  = BYTE_W'(1);
         end
         if (has_value) begin
            if (room) begin
               decoded_count_in = decoded_count_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Decoder state, updated as a byte leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_code_ff    <= '0;
         block_pos_ff     <= '0;
         decoded_count_ff <= '0;
         overflow_ff      <= 1'b0;
      end else if (in_valid_ff && advance) begin
         block_code_ff    <= block_code_in;
         block_pos_ff     <= block_pos_in;
         decoded_count_ff <= decoded_count_in;
         overflow_ff      <= overflow_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && emit;
      end
      if (advance && in_valid_ff && emit) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_status_ff <= rsp_status_in;
         rsp_length_ff <= rsp_length_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item_kind    = rsp_kind_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_frame_length = rsp_length_ff;

endmodule : cobs_frame_decoder_top

`default_nettype wire

@@ hw/rtl/cfd_checker.sv @@
// ----------------------------------------------------------------------------
// COBS frame decoder checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_checker
   import cfd_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_item_kind,
   input wire logic [BYTE_W-1:0]   rsp_payload_byte,
   input wire logic [1:0]          rsp_frame_status,
   input wire logic [LENGTH_W-1:0] rsp_frame_length
);

   logic rsp_payload;
   logic rsp_end;

   assign rsp_payload = rsp_valid && (rsp_item_kind == KIND_PAYLOAD);
   assign rsp_end     = rsp_valid && (rsp_item_kind == KIND_FRAME_END);

   // A payload request carries no frame status or length.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_payload |-> (rsp_frame_status == STATUS_GOOD) && (rsp_frame_length == '0))
      else $error("payload request carries frame status or length");

   // An empty frame reports zero length and a good frame a nonzero one.
   a_end_length: assert property (@(posedge clock) disable iff (reset)
      rsp_end |-> (rsp_payload_byte == '0) &&
         ((rsp_frame_status == STATUS_EMPTY) == (rsp_frame_length == '0) ||
          rsp_frame_status == STATUS_OVERFLOW))
      else $error("frame end length does not match its status");

   // A stalled response request holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_kind) &&
         $stable(rsp_payload_byte) && $stable(rsp_frame_status) &&
         $stable(rsp_frame_length))
      else $error("response request changed while stalled");

   // A request presented at reset never shows up as a response.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response appeared right after reset");

endmodule : cfd_checker

bind cobs_frame_decoder_top cfd_checker u_cfd_checker (.*);

`default_nettype wire

@@ tb/cfd_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame decoder checker
// Watches both channels of the decoder, predicts the decoded stream from the
// accepted link bytes and compares each response against the oldest prediction.
// ----------------------------------------------------------------------------

module cfd_frame_checker
   import cfd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic [BYTE_W-1:0]   req_rx_byte,

   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic                rsp_item_kind,
   input  wire logic [BYTE_W-1:0]   rsp_payload_byte,
   input  wire logic [1:0]          rsp_frame_status,
   input  wire logic [LENGTH_W-1:0] rsp_frame_length,

   output int                       mismatch_count,
   output int                       pending_count
);

   typedef struct {
      item_kind_type       kind;
      logic [BYTE_W-1:0]   data;
      frame_status_type    status;
      logic [LENGTH_W-1:0] length;
   } decoded_item_t;

   decoded_item_t awaited_items[$];

   // Decoder state as the block should hold it.
   logic [BYTE_W-1:0] block_code;
   logic [BYTE_W-1:0] block_pos;
   int                kept_count;
   bit                overflowed;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic void clear_frame_state();
      block_code = '0;
      block_pos  = '0;
      kept_count = 0;
      overflowed = 1'b0;
   endfunction

   // Works out what one link byte produces, and moves the state along.
   function automatic void decode_link_byte(input logic [BYTE_W-1:0] rx,
                                            output bit produced,
                                            output decoded_item_t item);
      bit                stripped;
      logic [BYTE_W-1:0] value;
      produced = 1'b0;
      item = '{kind: KIND_PAYLOAD, data: '0, status: STATUS_GOOD, length: '0};
      if (rx == DELIMITER) begin
         item.kind = KIND_FRAME_END;
         if (overflowed)
            item.status = STATUS_OVERFLOW;
         else if (kept_count == 0)
            item.status = STATUS_EMPTY;
         item.length = (kept_count > MAX_LENGTH) ? LENGTH_W'(MAX_LENGTH)
                                                 : LENGTH_W'(kept_count);
         clear_frame_state();
         produced = 1'b1;
         return;
      end
      if (block_pos < block_code) begin
         block_pos = block_pos + 1'b1;
         value = rx;
      end else begin
         // A code byte: the block it closes may stand for a stripped zero.
         stripped = (block_code != '0) && (block_code != FULL_BLOCK_CODE);
         block_code = rx;
         block_pos = 8'd1;
         if (!stripped)
            return;
         value = '0;
      end
      if (kept_count < FRAME_CAPACITY) begin
         kept_count++;
         item.data = value;
         produced = 1'b1;
      end else begin
         overflowed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      bit            produced;
      decoded_item_t item;
      decoded_item_t oldest;
      if (reset) begin
         clear_frame_state();
         awaited_items.delete();
      end else begin
         if (req_valid && req_ready) begin
            decode_link_byte(req_rx_byte, produced, item);
            if (produced)
               awaited_items.push_back(item);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_items.size() == 0) begin
               $error("response with nothing awaited: kind %0d byte %0d status %0d length %0d",
                      rsp_item_kind, rsp_payload_byte, rsp_frame_status, rsp_frame_length);
               mismatch_count++;
            end else begin
               oldest = awaited_items.pop_front();
               if (rsp_item_kind !== oldest.kind) begin
                  $error("item_kind: expected %0d, actual %0d", oldest.kind, rsp_item_kind);
                  mismatch_count++;
               end
               if (rsp_payload_byte !== oldest.data) begin
                  $error("payload_byte: expected %0d, actual %0d",
                         oldest.data, rsp_payload_byte);
                  mismatch_count++;
               end
               if (rsp_frame_status !== oldest.status) begin
                  $error("frame_status: expected %0d, actual %0d",
                         oldest.status, rsp_frame_status);
                  mismatch_count++;
               end
               if (rsp_frame_length !== oldest.length) begin
                  $error("frame_length: expected %0d, actual %0d",
                         oldest.length, rsp_frame_length);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count <= awaited_items.size();
   end

endmodule : cfd_frame_checker

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame decoder testbench
// Feeds hand-picked and randomly encoded link frames into the decoder with
// random gaps and stalls on both sides; a checker beside the block compares
// every decoded byte and frame-end request against its own prediction.
// ----------------------------------------------------------------------------

module testbench;
   import cfd_pkg::*;

   typedef logic [BYTE_W-1:0] byte_q_t[$];

   // Roughly how many link bytes the random part sends before it stops.
   localparam int ITEM_TARGET     = 1600;
   // Cycles without any handshake on either channel before the run gives up.
   // The longest legal quiet stretch is the receiver hold-off below.
   localparam int IDLE_LIMIT      = 1000;
   localparam int HOLD_OFF_CYCLES = 120;
   // The block holds bytes only in its input and response registers, so these
   // extra cycles at the end are enough to catch any stray response.
   localparam int DRAIN_CYCLES    = 10;

   // Hand-picked frames. Each line is one frame, closed by a delimiter.
   localparam logic [BYTE_W-1:0] DIRECTED_BYTES [22] = '{
      // Empty frame straight after reset.
      DELIMITER,
      // A lone code byte: its trailing implied zero is never sent.
      8'h01, DELIMITER,
      // One payload byte with every bit set.
      8'h02, 8'hff, DELIMITER,
      // Two blocks that each close on a stripped zero, then a short one.
      8'h03, 8'h01, 8'h80, 8'h02, 8'h7f, 8'h01, DELIMITER,
      // A full-size block code cut short by the delimiter.
      FULL_BLOCK_CODE, 8'h11, 8'h22, DELIMITER,
      // A short block followed by a full-size code byte, which still owes
      // the zero of the short block.
      8'h02, 8'haa, FULL_BLOCK_CODE, 8'hbb, DELIMITER
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_item_kind;
   logic [BYTE_W-1:0]   rsp_payload_byte;
   logic [1:0]          rsp_frame_status;
   logic [LENGTH_W-1:0] rsp_frame_length;

   int mismatch_count;
   int pending_count;

   // While set, neither side idles, so the block runs at full rate.
   bit steady_phase = 1'b0;
   // The stimulus asks for a long receiver hold-off by bumping this count;
   // the receiver process serves each ask once.
   int hold_off_asks    = 0;
   int hold_offs_served = 0;
   int bytes_sent       = 0;
   int quiet_cycles     = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cobs_frame_decoder_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length)
   );

   cfd_frame_checker frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // Idle length for either side: mostly none, sometimes a few cycles and
   // now and then a long gap. Nothing while the steady phase runs.
   function automatic int pick_gap();
      int roll;
      if (steady_phase)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Offers one link byte, after an optional gap, and waits until the block
   // takes the request. Valid stays high on return, so back-to-back bytes
   // never drop valid in between.
   task automatic send_link_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Stops offering and waits until every predicted response has arrived.
   // The task always waits for a clock edge after valid falls, so the next
   // request cannot raise it again in the same time step.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // COBS-encodes a payload and sends it with its delimiter. A broken frame
   // keeps only a random prefix of the encoding before the delimiter.
   task automatic send_cobs_frame(input byte_q_t payload, input bit broken);
      byte_q_t encoded;
      int      code_at;
      int      run;
      int      keep;
      encoded = '{8'h00};
      code_at = 0;
      run     = 1;
      foreach (payload[i]) begin
         if (payload[i] == DELIMITER) begin
            encoded[code_at] = BYTE_W'(run);
            code_at = encoded.size();
            encoded.push_back(8'h00);
            run = 1;
         end else begin
            encoded.push_back(payload[i]);
            run++;
            // A block of 254 payload bytes closes with a full-size code.
            if (run == FULL_BLOCK_CODE) begin
               encoded[code_at] = BYTE_W'(run);
               code_at = encoded.size();
               encoded.push_back(8'h00);
               run = 1;
            end
         end
      end
      encoded[code_at] = BYTE_W'(run);
      keep = broken ? $urandom_range(0, encoded.size() - 1) : encoded.size();
      for (int i = 0; i < keep; i++)
         send_link_byte(encoded[i]);
      send_link_byte(DELIMITER);
   endtask

   // Watchdog: a hung block shows up as a long run of cycles in which
   // neither channel completes a handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver. Each cycle it may decide to stall for a random stretch; when
   // the stimulus asks for a hold-off it stalls for a long, fixed stretch so
   // that the block fills up and pushes back on the sender.
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (hold_offs_served < hold_off_asks) begin
            hold_offs_served++;
            stall = HOLD_OFF_CYCLES;
         end else if ($urandom_range(0, 3) == 0) begin
            stall = pick_gap();
         end else begin
            stall = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Sender and verdict.
   initial begin
      byte_q_t payload;
      int      frame_idx;
      int      shape;
      int      len;
      int      zero_pct;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames first, then let them drain so the random part
      // starts from a quiet block.
      foreach (DIRECTED_BYTES[i])
         send_link_byte(DIRECTED_BYTES[i]);
      wait_for_drain();

      // Random frames. Most are well-formed encodings of random payloads,
      // since only those walk through full blocks and stripped zeros; the
      // rest are raw noise and frames cut off in the middle. Every twelfth
      // frame that is not noise carries 240 to 300 payload bytes, around the frame capacity.
      frame_idx = 0;
      while (bytes_sent < ITEM_TARGET) begin
         steady_phase = (frame_idx % 9 == 4);
         if (frame_idx == 12)
            hold_off_asks++;
         if (frame_idx == 25)
            wait_for_drain();
         shape = $urandom_range(0, 99);
         if (shape < 10) begin
            len = $urandom_range(1, 20);
            repeat (len) send_link_byte(BYTE_W'($urandom_range(0, 255)));
            send_link_byte(DELIMITER);
         end else begin
            if (frame_idx % 12 == 7) begin
               len      = $urandom_range(240, 300);
               zero_pct = $urandom_range(0, 2);
            end else begin
               len = $urandom_range(0, 30);
               case ($urandom_range(0, 3))
                  0: zero_pct = 0;
                  1: zero_pct = 10;
                  2: zero_pct = 50;
                  default: zero_pct = 100;
               endcase
            end
            payload.delete();
            repeat (len) begin
               if ($urandom_range(0, 99) < zero_pct)
                  payload.push_back(DELIMITER);
               else
                  payload.push_back(BYTE_W'($urandom_range(1, 255)));
            end
            send_cobs_frame(payload, shape < 22);
         end
         frame_idx++;
      end
      steady_phase = 1'b0;

      // Everything is sent: wait for the last responses, then give the
      // block a few more cycles to show any extra one.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule : testbench
